// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared definitions for the range mode query block
// Field widths, request codes, default sizes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Fixed widths of the request and result fields.
  localparam int FUNC_W  = 1;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 10;
  localparam int COUNT_W = 11;

  // Default sizes of the element store and the value range.
  localparam int ARRAY_DEPTH_DEF = 1024;
  localparam int VALUE_LIMIT_DEF = 1024;

  // Request codes carried on the func field.
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_DRAIN,
    ST_RESTORE,
    ST_RDRAIN,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic elem_wr;
    logic load;
    logic issue;
    logic restore;
    logic rewind;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic idx_last;
    logic pipe_busy;
  } status_t;

endpackage

// ===== rtl/rmq_ram.sv =====
// ----------------------------------------------------------------------------
// rmq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered (old data is
// returned when reading an address that is written in the same cycle).
// ----------------------------------------------------------------------------
module rmq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmq_ctrl: controller state machine for the range mode query block
// Sequences the count table clearing pass, element writes, the counting
// pass, the restore pass and the result handoff.
// ----------------------------------------------------------------------------
module rmq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rmq_pkg::FUNC_W-1:0]   in_func,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rmq_pkg::cmd_t                cmd,
  input  rmq_pkg::status_t             status
);
  import rmq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_QUERY) begin
            cmd.load  = 1'b1;
            state_nxt = ST_COUNT;
          end else begin
            cmd.elem_wr = 1'b1;
          end
        end
      end
      ST_COUNT: begin
        cmd.issue = 1'b1;
        if (status.idx_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.rewind = 1'b1;
        if (!status.pipe_busy) begin
          state_nxt = ST_RESTORE;
        end
      end
      ST_RESTORE: begin
        cmd.issue   = 1'b1;
        cmd.restore = 1'b1;
        if (status.idx_last) begin
          state_nxt = ST_RDRAIN;
        end
      end
      ST_RDRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

endmodule

// ===== rtl/rmq_datapath.sv =====
// ----------------------------------------------------------------------------
// rmq_datapath: storage and counting pipeline of the range mode query block
// Holds the element store and count table, walks the query range through a
// three-stage read / read / update pipeline and keeps the running mode.
// ----------------------------------------------------------------------------
module rmq_datapath #(
  parameter int ARRAY_DEPTH = rmq_pkg::ARRAY_DEPTH_DEF,
  parameter int VALUE_LIMIT = rmq_pkg::VALUE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmq_pkg::cmd_t                 cmd,
  output rmq_pkg::status_t              status,
  input  logic [rmq_pkg::INDEX_W-1:0]   in_first_index,
  input  logic [rmq_pkg::INDEX_W-1:0]   in_second_index,
  input  logic [rmq_pkg::VALUE_W-1:0]   in_element_value,
  output logic [rmq_pkg::VALUE_W-1:0]   out_mode_value,
  output logic [rmq_pkg::COUNT_W-1:0]   out_mode_count
);
  import rmq_pkg::*;

  localparam int AW  = $clog2(ARRAY_DEPTH);
  localparam int VAW = $clog2(VALUE_LIMIT);
  localparam int CW  = $clog2(ARRAY_DEPTH + 1);
  localparam int VXW = (VAW > VALUE_W) ? VAW : VALUE_W;
  localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

  // Range walk and clearing pass.
  logic [AW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic [VAW-1:0] clr_r, clr_nxt;

  // Pipeline stage valids and payload.
  logic           p1_valid_r, p1_restore_r, p2_valid_r;
  logic [VAW-1:0] p2_val_r;
  logic           fwd_valid_r;
  logic [VAW-1:0] fwd_addr_r;
  logic [CW-1:0]  fwd_data_r;

  // Running mode and result register.
  logic [VAW-1:0] best_value_r, best_value_nxt, out_value_r;
  logic [CW-1:0]  best_count_r, best_count_nxt, out_count_r;

  // Memory ports.
  logic           elem_wr_en;
  logic [AW-1:0]  elem_wr_addr;
  logic [VAW-1:0] elem_wr_data, elem_rd_data;
  logic           cnt_wr_en;
  logic [VAW-1:0] cnt_wr_addr, cnt_rd_addr;
  logic [CW-1:0]  cnt_wr_data, cnt_rd_data;

  logic [31:0]    first_w, second_w, value_w, rd_w;
  logic [31:0]    first_c, second_c, value_c, rd_c;
  logic [VAW-1:0] s1_val;
  logic [CW-1:0]  c_old, c_new;

  logic [VXW-1:0] value_ext;
  logic [CXW-1:0] count_ext;

  rmq_ram #(.WIDTH(VAW), .DEPTH(ARRAY_DEPTH)) u_elem_ram (
    .clk     (clk),
    .wr_en   (elem_wr_en),
    .wr_addr (elem_wr_addr),
    .wr_data (elem_wr_data),
    .rd_addr (idx_r),
    .rd_data (elem_rd_data)
  );

  rmq_ram #(.WIDTH(CW), .DEPTH(VALUE_LIMIT)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data)
  );

  // Saturation of request fields to the array and value ranges.
  always_comb begin
    first_w  = 32'(in_first_index);
    second_w = 32'(in_second_index);
    value_w  = 32'(in_element_value);
    rd_w     = 32'(elem_rd_data);
    first_c  = (first_w  >= 32'(ARRAY_DEPTH)) ? 32'(ARRAY_DEPTH - 1) : first_w;
    second_c = (second_w >= 32'(ARRAY_DEPTH)) ? 32'(ARRAY_DEPTH - 1) : second_w;
    value_c  = (value_w  >= 32'(VALUE_LIMIT)) ? 32'(VALUE_LIMIT - 1) : value_w;
    rd_c     = (rd_w     >= 32'(VALUE_LIMIT)) ? 32'(VALUE_LIMIT - 1) : rd_w;
    s1_val   = VAW'(rd_c);
  end

  assign elem_wr_en   = cmd.elem_wr && (first_w < 32'(ARRAY_DEPTH));
  assign elem_wr_addr = AW'(first_w);
  assign elem_wr_data = VAW'(value_c);

  // Count stage: forward the previous update when it hits the same value.
  always_comb begin
    c_old = (fwd_valid_r && (fwd_addr_r == p2_val_r)) ? fwd_data_r : cnt_rd_data;
    c_new = c_old + 1'b1;
  end

  assign cnt_rd_addr = s1_val;

  always_comb begin
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = clr_r;
    cnt_wr_data = '0;
    if (cmd.clr_step) begin
      cnt_wr_en = 1'b1;
    end else if (p2_valid_r) begin
      cnt_wr_en   = 1'b1;
      cnt_wr_addr = p2_val_r;
      cnt_wr_data = c_new;
    end else if (p1_valid_r && p1_restore_r) begin
      // Every count was zero before the query, so restoring is a plain clear.
      cnt_wr_en   = 1'b1;
      cnt_wr_addr = s1_val;
    end
  end

  always_comb begin
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    clr_nxt        = clr_r;
    best_value_nxt = best_value_r;
    best_count_nxt = best_count_r;
    if (cmd.clr_step) begin
      clr_nxt = clr_r + 1'b1;
    end
    if (cmd.load) begin
      if (first_c > second_c) begin
        lo_nxt = AW'(second_c);
        hi_nxt = AW'(first_c);
      end else begin
        lo_nxt = AW'(first_c);
        hi_nxt = AW'(second_c);
      end
      idx_nxt        = lo_nxt;
      best_value_nxt = '0;
      best_count_nxt = '0;
    end
    if (cmd.issue) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.rewind) begin
      idx_nxt = lo_r;
    end
    if (p2_valid_r) begin
      if ((c_new > best_count_r) ||
          ((c_new == best_count_r) && (p2_val_r < best_value_r))) begin
        best_value_nxt = p2_val_r;
        best_count_nxt = c_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      p1_valid_r   <= 1'b0;
      p2_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      best_value_r <= '0;
      best_count_r <= '0;
    end else begin
      clr_r        <= clr_nxt;
      p1_valid_r   <= cmd.issue;
      p2_valid_r   <= p1_valid_r && !p1_restore_r;
      fwd_valid_r  <= p2_valid_r;
      best_value_r <= best_value_nxt;
      best_count_r <= best_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    idx_r        <= idx_nxt;
    p1_restore_r <= cmd.restore;
    p2_val_r     <= s1_val;
    fwd_addr_r   <= p2_val_r;
    fwd_data_r   <= c_new;
    if (cmd.out_load) begin
      out_value_r <= best_value_r;
      out_count_r <= best_count_r;
    end
  end

  assign status.clr_last  = (clr_r == VAW'(VALUE_LIMIT - 1));
  assign status.idx_last  = (idx_r == hi_r);
  assign status.pipe_busy = p1_valid_r || p2_valid_r;

  assign value_ext      = VXW'(out_value_r);
  assign count_ext      = CXW'(out_count_r);
  assign out_mode_value = value_ext[VALUE_W-1:0];
  assign out_mode_count = count_ext[COUNT_W-1:0];

endmodule

// ===== rtl/range_mode_query_top.sv =====
// ----------------------------------------------------------------------------
// range_mode_query_top: stored array with range mode queries
// Write requests store one element; query requests return the most frequent
// value between two indices (smallest on ties) and its count.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Payload
//   in_       input       in_valid/in_stall    func, first_index, second_index,
//                                              element_value
//   out_      output      out_valid/out_stall  mode_value, mode_count
//
// A write request leaves the block idle. A query keeps in_stall high from its
// accepting edge while it counts each value in the count table, drains the
// pipeline, clears those counts again, drains again and loads the output
// register, where the result then appears.
// After reset the count table is cleared one entry per cycle, during which
// in_stall stays high.
// The result sits in an output register; a stalled result only delays the
// end of the next query, while write requests keep flowing until that query is taken.
//
module range_mode_query_top #(
  parameter int ARRAY_DEPTH = rmq_pkg::ARRAY_DEPTH_DEF,
  parameter int VALUE_LIMIT = rmq_pkg::VALUE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rmq_pkg::FUNC_W-1:0]    in_func,
  input  logic [rmq_pkg::INDEX_W-1:0]   in_first_index,
  input  logic [rmq_pkg::INDEX_W-1:0]   in_second_index,
  input  logic [rmq_pkg::VALUE_W-1:0]   in_element_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rmq_pkg::VALUE_W-1:0]   out_mode_value,
  output logic [rmq_pkg::COUNT_W-1:0]   out_mode_count
);
  import rmq_pkg::*;

  // The controller only issues commands; all storage and arithmetic live in
  // the datapath.
  cmd_t    cmd;
  status_t status;

  rmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath counts elements through a pipeline of element read, count
  // read and count update, with forwarding between back-to-back updates.
  rmq_datapath #(
    .ARRAY_DEPTH (ARRAY_DEPTH),
    .VALUE_LIMIT (VALUE_LIMIT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_first_index   (in_first_index),
    .in_second_index  (in_second_index),
    .in_element_value (in_element_value),
    .out_mode_value   (out_mode_value),
    .out_mode_count   (out_mode_count)
  );

endmodule

// ===== rtl/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker: port-level assertions for the range mode query block
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module rmq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [rmq_pkg::FUNC_W-1:0]    in_func,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rmq_pkg::VALUE_W-1:0]   out_mode_value,
  input logic [rmq_pkg::COUNT_W-1:0]   out_mode_count
);
  import rmq_pkg::*;

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode_value) &&
      $stable(out_mode_count))
    else $error("stalled result changed");

  // The count table is cleared after reset before any request is taken.
  assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request path open during count table clear");

  // A query keeps the block busy on the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_QUERY) |=> in_stall)
    else $error("query did not occupy the block");

  // A write request never produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_WRITE) |=> !$rose(out_valid))
    else $error("write request produced a result");

  // Every reported mode occurs at least once.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mode_count != '0))
    else $error("result with zero count");

endmodule

bind range_mode_query_top rmq_checker u_rmq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_mode_value (out_mode_value),
  .out_mode_count (out_mode_count)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for range_mode_query_top
// Sends write and query requests through the valid/stall input channel. It
// keeps its own copy of the element array to predict the mode and the count
// of every query, and checks each result against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
  import rmq_pkg::*;

  // Sizes of the block under test and run limits. Queries stay inside a
  // window at the start of the array that is written completely, plus the
  // last element. The limit covers the clearing pass after reset and every
  // request as a query over the whole window under heavy stalling, taken
  // several times over.
  localparam int ARRAY_DEPTH  = ARRAY_DEPTH_DEF;
  localparam int VALUE_LIMIT  = VALUE_LIMIT_DEF;
  localparam int WINDOW_DEPTH = 48;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 50;
  localparam int HOLD_CYCLES  = 400;

  // One request as it travels on the input channel.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
    logic [VALUE_W-1:0] element_value;
  } rmq_request_t;

  // One query result as it leaves on the output channel.
  typedef struct packed {
    logic [VALUE_W-1:0] mode_value;
    logic [COUNT_W-1:0] mode_count;
  } mode_result_t;

  // All inputs of the block start at known values.
  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  in_func          = FUNC_WRITE;
  logic [INDEX_W-1:0] in_first_index   = '0;
  logic [INDEX_W-1:0] in_second_index  = '0;
  logic [VALUE_W-1:0] in_element_value = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [VALUE_W-1:0] out_mode_value;
  logic [COUNT_W-1:0] out_mode_count;

  // Shadow copy of the element array and a per-value tally used by the
  // mode prediction. The tally is put back to zero after every query.
  logic [VALUE_W-1:0] stored_elems [ARRAY_DEPTH];
  int unsigned        value_tally  [VALUE_LIMIT];

  // Query results that have been predicted but not yet seen, oldest first.
  mode_result_t pending_modes [$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_hold_request;
  int unsigned stall_hold_left;

  range_mode_query_top #(
    .ARRAY_DEPTH(ARRAY_DEPTH),
    .VALUE_LIMIT(VALUE_LIMIT)
  ) i_dut (.*);

  always #5 clk = ~clk;

  // Values outside the value range saturate to the largest legal value.
  function automatic logic [VALUE_W-1:0] saturate_value(input int unsigned v);
    return (v >= VALUE_LIMIT) ? VALUE_W'(VALUE_LIMIT - 1) : VALUE_W'(v);
  endfunction

  // Mode of the shadow array between two indices, inclusive. The indices
  // saturate to the last element and are put in order, so the range is never
  // empty. A value that reaches the best count later only wins a tie if it
  // is smaller than the current best.
  function automatic mode_result_t predict_mode(input int unsigned end_a,
                                                input int unsigned end_b);
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  val;
    int unsigned  best_value;
    int unsigned  best_count;
    mode_result_t res;
    lo = (end_a >= ARRAY_DEPTH) ? ARRAY_DEPTH - 1 : end_a;
    hi = (end_b >= ARRAY_DEPTH) ? ARRAY_DEPTH - 1 : end_b;
    if (lo > hi) begin
      val = lo;
      lo  = hi;
      hi  = val;
    end
    best_value = 0;
    best_count = 0;
    for (int unsigned i = lo; i <= hi; i++) begin
      val = saturate_value(stored_elems[i]);
      value_tally[val]++;
      if (value_tally[val] > best_count ||
          (value_tally[val] == best_count && val < best_value)) begin
        best_value = val;
        best_count = value_tally[val];
      end
    end
    for (int unsigned i = lo; i <= hi; i++) begin
      value_tally[saturate_value(stored_elems[i])]--;
    end
    res.mode_value = VALUE_W'(best_value);
    res.mode_count = COUNT_W'(best_count);
    return res;
  endfunction

  // Request builders. Fields the block ignores carry random bits so that
  // they cannot influence the result unnoticed.
  function automatic rmq_request_t write_req(input int unsigned idx, input int unsigned val);
    rmq_request_t r;
    r.func          = FUNC_WRITE;
    r.first_index   = INDEX_W'(idx);
    r.second_index  = INDEX_W'($urandom);
    r.element_value = VALUE_W'(val);
    return r;
  endfunction

  function automatic rmq_request_t query_req(input int unsigned end_a, input int unsigned end_b);
    rmq_request_t r;
    r.func          = FUNC_QUERY;
    r.first_index   = INDEX_W'(end_a);
    r.second_index  = INDEX_W'(end_b);
    r.element_value = VALUE_W'($urandom);
    return r;
  endfunction

  // Offers one request and returns at the rising edge where it is accepted.
  // Random idle cycles come only before valid is raised; once offered, the
  // request stays on the channel unchanged until the block takes it. The
  // shadow array and the expected results are updated at that same edge.
  task automatic send_request(input rmq_request_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= req.func;
    in_first_index   <= req.first_index;
    in_second_index  <= req.second_index;
    in_element_value <= req.element_value;
    do @(posedge clk); while (in_stall);
    if (req.func == FUNC_WRITE) begin
      if (req.first_index < ARRAY_DEPTH) begin
        stored_elems[req.first_index] = saturate_value(req.element_value);
      end
    end else begin
      pending_modes.push_back(predict_mode(req.first_index, req.second_index));
    end
  endtask

  // Takes valid down and waits until every query result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk);
  endtask

  // Hand-picked requests on a small corner of the array: single elements,
  // reversed bounds, ties that must go to the smaller value, both value
  // extremes, an overwrite, and the last index on both index fields.
  task automatic test_directed_cases();
    send_request(write_req(0, 5));
    send_request(write_req(1, 3));
    send_request(write_req(2, 5));
    send_request(write_req(3, 3));
    send_request(write_req(4, 0));
    send_request(write_req(5, VALUE_LIMIT - 1));
    send_request(write_req(6, VALUE_LIMIT - 1));
    send_request(write_req(7, 0));
    send_request(write_req(ARRAY_DEPTH - 1, 512));
    send_request(query_req(2, 2));
    send_request(query_req(0, 3));
    send_request(query_req(7, 0));
    send_request(query_req(5, 6));
    send_request(query_req(6, 4));
    send_request(query_req(ARRAY_DEPTH - 1, ARRAY_DEPTH - 1));
    send_request(write_req(4, VALUE_LIMIT - 1));
    send_request(query_req(0, 7));
  endtask

  // Fills the whole query window with the largest value and asks for the
  // whole window, which gives the largest count. Then it refills the window
  // with mostly small values, so that later queries anywhere in it see real
  // competition between values, and asks for the whole window again with
  // reversed bounds.
  task automatic test_full_range();
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      send_request(write_req(i, VALUE_LIMIT - 1));
    end
    send_request(query_req(0, WINDOW_DEPTH - 1));
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_request(write_req(i, $urandom_range(0, VALUE_LIMIT - 1)));
      end else begin
        send_request(write_req(i, $urandom_range(0, 5)));
      end
    end
    send_request(query_req(WINDOW_DEPTH - 1, 0));
  endtask

  // Random mix of writes and queries. Values come mostly from a small set so
  // that ranges hold repeats and ties. Writes land mostly in the window and
  // now and then anywhere in the array. Most ranges are short; a few span
  // much of the window.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_requests);
    int unsigned lo;
    int unsigned hi;
    int unsigned idx;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned k = 0; k < n_requests; k++) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 7) == 0) begin
          idx = $urandom_range(0, ARRAY_DEPTH - 1);
        end else begin
          idx = $urandom_range(0, WINDOW_DEPTH - 1);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_request(write_req(idx, $urandom_range(0, VALUE_LIMIT - 1)));
        end else begin
          send_request(write_req(idx, $urandom_range(0, 7)));
        end
      end else begin
        lo = $urandom_range(0, WINDOW_DEPTH - 1);
        if ($urandom_range(0, 9) == 0) begin
          hi = lo + $urandom_range(0, WINDOW_DEPTH - 1);
        end else begin
          hi = lo + $urandom_range(0, 12);
        end
        if (hi > WINDOW_DEPTH - 1) begin
          hi = WINDOW_DEPTH - 1;
        end
        if ($urandom_range(0, 1) == 1) begin
          send_request(query_req(hi, lo));
        end else begin
          send_request(query_req(lo, hi));
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering queries and writes without gaps. The first result sits in the
  // output register, the next query cannot finish, and the block stalls its
  // input. After that the sender pauses until every result is back, and a
  // few more requests follow on the emptied block.
  task automatic test_backpressure();
    int unsigned lo;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    stall_hold_request = HOLD_CYCLES;
    for (int k = 0; k < 6; k++) begin
      lo = $urandom_range(0, WINDOW_DEPTH - 33);
      send_request(query_req(lo, lo + $urandom_range(0, 32)));
      send_request(write_req($urandom_range(0, ARRAY_DEPTH - 1), $urandom_range(0, 7)));
    end
    wait_drained();
    for (int k = 0; k < 4; k++) begin
      lo = $urandom_range(0, WINDOW_DEPTH - 17);
      send_request(write_req(lo, $urandom_range(0, 7)));
      send_request(query_req(lo + $urandom_range(0, 16), lo));
    end
  endtask

  // Receiver side. A hold request from a test turns into a long stall that
  // this process counts down; otherwise stall is random at the current rate.
  always @(negedge clk) begin
    if (stall_hold_request != 0) begin
      stall_hold_left    = stall_hold_request;
      stall_hold_request = 0;
    end
    if (stall_hold_left != 0) begin
      stall_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result checker. Every accepted result is matched against the oldest
  // expected one; a result with nothing expected is an error by itself.
  always @(posedge clk) begin
    mode_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_modes.size() == 0) begin
        $display("%0t: unexpected result, actual mode_value %0d mode_count %0d",
                 $time, out_mode_value, out_mode_count);
        error_count++;
      end else begin
        want = pending_modes.pop_front();
        if (out_mode_value !== want.mode_value) begin
          $display("%0t: mode_value mismatch, expected %0d, actual %0d",
                   $time, want.mode_value, out_mode_value);
          error_count++;
        end
        if (out_mode_count !== want.mode_count) begin
          $display("%0t: mode_count mismatch, expected %0d, actual %0d",
                   $time, want.mode_count, out_mode_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_modes.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Test sequence. Reset is held at the start; the block then clears its
  // count table and keeps its input stalled until it is done, which the
  // first request simply waits out. The first idling setting has a slow
  // receiver, the second a slow sender, the last no idling at all.
  initial begin
    send_idle_pct = 18;
    recv_idle_pct = 71;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_full_range();
    test_random_traffic(18, 71, 52);
    test_random_traffic(71, 18, 52);
    test_random_traffic(0, 0, 51);
    test_backpressure();

    // Nothing must come out once every expected result has been seen.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rmq_pkg.sv
rtl/rmq_ram.sv
rtl/rmq_ctrl.sv
rtl/rmq_datapath.sv
rtl/range_mode_query_top.sv
rtl/rmq_checker.sv
bench/tb_top.sv
